// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/til_pkg.sv =====
// ----------------------------------------------------------------------------
// til_pkg
// Types and constants for the timeline interval activator.
// ----------------------------------------------------------------------------
package til_pkg;

   localparam int SLOTS_DEF    = 32;
   localparam int TIME_W       = 32;
   localparam int SLOT_FIELD_W = 5;
   localparam int MASK_W       = 32;
   localparam int CMD_W        = 2;
   localparam int REQ_DATA_W   = 104;
   localparam int RSP_DATA_W   = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET    = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_REBUILD,
      MODE_FWD,
      MODE_BACK
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] end_time;
      logic signed [TIME_W-1:0] start_time;
   } bound_type;

endpackage

// ===== hdl/timeline_interval_activator_top.sv =====
// ----------------------------------------------------------------------------
// timeline_interval_activator_top
// Interval slot store with an active mask driven by timeline commands.
// ----------------------------------------------------------------------------
// One command is taken at a time. A set-time command to the current time, a
// rejected insert or delete and the unused command code go straight to the
// done state. A set-time move and a good insert or delete (which first passes
// a write state) walk the slots one by one through a single compare unit fed
// by the single read port of the bound store, with a read state and an update
// state per slot. A new command is taken only once the result is loaded, which
// waits while the previous result is still unaccepted on the result channel.
module timeline_interval_activator_top #(
   parameter int SLOTS = til_pkg::SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // slot[4:0], start_time[36:5], end_time[68:37], new_time[100:69], zero pad
   input  logic [til_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [til_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // active_mask[31:0]
   output logic [til_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // bad_request[0]
   output logic                               rsp_tuser
);

   `include "assert_macros.svh"

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   til_pkg::state_type                  state_ff, state_in;
   til_pkg::cmd_type                    cmd_ff;
   til_pkg::mode_type                   mode_ff;
   til_pkg::bound_type                  bound_ff;
   logic signed [til_pkg::TIME_W-1:0]   time_ff;
   logic signed [til_pkg::TIME_W-1:0]   last_time_ff;
   logic [IDX_W-1:0]                    slot_ff;
   logic [IDX_W-1:0]                    idx_ff;
   logic                                bad_ff;
   logic [SLOTS-1:0]                    valid_ff;
   logic [SLOTS-1:0]                    active_ff;
   logic                                rsp_tvalid_ff;
   logic [til_pkg::MASK_W-1:0]          rsp_mask_ff;
   logic                                rsp_bad_ff;

   til_pkg::cmd_type                    req_cmd;
   logic [til_pkg::SLOT_FIELD_W-1:0]    req_slot;
   til_pkg::bound_type                  req_bound;
   logic signed [til_pkg::TIME_W-1:0]   req_time;
   logic [IDX_W-1:0]                    req_idx;
   logic                                req_in_range;
   logic                                req_bad;
   logic                                accept;
   logic                                idx_last;
   logic                                mem_wr_en;
   logic                                mem_rd_en;
   logic                                eval_en;
   logic                                load_rsp;
   logic                                next_bit;
   til_pkg::bound_type                  rd_bound;
   logic [til_pkg::MASK_W-1:0]          active32;

   assign req_cmd       = til_pkg::cmd_type'(req_tuser);
   assign req_slot      = req_tdata[4:0];
   assign req_bound.start_time = req_tdata[36:5];
   assign req_bound.end_time   = req_tdata[68:37];
   assign req_time      = req_tdata[100:69];
   assign req_idx       = IDX_W'(req_slot);
   assign req_in_range  = (32'(req_slot) < 32'(SLOTS));
   assign accept        = req_tvalid && req_tready;
   assign idx_last      = (idx_ff == IDX_W'(SLOTS - 1));

   always_comb begin
      unique case (req_cmd)
         til_pkg::CMD_INSERT: req_bad = !req_in_range || valid_ff[req_idx];
         til_pkg::CMD_DELETE: req_bad = !req_in_range || !valid_ff[req_idx];
         default:             req_bad = 1'b0;
      endcase
   end

   for (genvar g = 0; g < til_pkg::MASK_W; g++) begin : g_mask
      if (g < SLOTS) begin : g_slot
         assign active32[g] = active_ff[g];
      end else begin : g_pad
         assign active32[g] = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         til_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  til_pkg::CMD_SET: begin
                     state_in = (req_time == last_time_ff) ? til_pkg::ST_DONE
                                                           : til_pkg::ST_READ;
                  end
                  til_pkg::CMD_INSERT, til_pkg::CMD_DELETE: begin
                     state_in = req_bad ? til_pkg::ST_DONE : til_pkg::ST_WRITE;
                  end
                  default: state_in = til_pkg::ST_DONE;
               endcase
            end
         end
         til_pkg::ST_WRITE: state_in = til_pkg::ST_READ;
         til_pkg::ST_READ:  state_in = til_pkg::ST_EVAL;
         til_pkg::ST_EVAL:  state_in = idx_last ? til_pkg::ST_DONE : til_pkg::ST_READ;
         til_pkg::ST_DONE:  state_in = load_rsp ? til_pkg::ST_IDLE : til_pkg::ST_DONE;
         default:           state_in = til_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      eval_en    = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         til_pkg::ST_IDLE:  req_tready = 1'b1;
         til_pkg::ST_WRITE: mem_wr_en  = (cmd_ff == til_pkg::CMD_INSERT);
         til_pkg::ST_READ:  mem_rd_en  = 1'b1;
         til_pkg::ST_EVAL:  eval_en    = 1'b1;
         til_pkg::ST_DONE:  load_rsp   = !rsp_tvalid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   til_bound_mem #(
      .SLOTS (SLOTS)
   ) u_bound_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (slot_ff),
      .wr_data (bound_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_bound)
   );

   til_cross_unit u_cross_unit (
      .mode       (mode_ff),
      .bound      (rd_bound),
      .last_time  (last_time_ff),
      .new_time   (time_ff),
      .slot_valid (valid_ff[idx_ff]),
      .cur_bit    (active_ff[idx_ff]),
      .next_bit   (next_bit)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= til_pkg::ST_IDLE;
         valid_ff      <= '0;
         active_ff     <= '0;
         last_time_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            idx_ff <= '0;
         end
         if (state_ff == til_pkg::ST_WRITE) begin
            valid_ff[slot_ff] <= (cmd_ff == til_pkg::CMD_INSERT);
         end
         if (eval_en) begin
            active_ff[idx_ff] <= next_bit;
            if (!idx_last) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         if (load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
            if (cmd_ff == til_pkg::CMD_SET) begin
               last_time_ff <= time_ff;
            end
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         slot_ff  <= req_idx;
         bound_ff <= req_bound;
         time_ff  <= req_time;
         bad_ff   <= req_bad;
         if (req_cmd == til_pkg::CMD_INSERT || req_cmd == til_pkg::CMD_DELETE) begin
            mode_ff <= til_pkg::MODE_REBUILD;
         end else if (req_time > last_time_ff) begin
            mode_ff <= til_pkg::MODE_FWD;
         end else begin
            mode_ff <= til_pkg::MODE_BACK;
         end
      end
      if (load_rsp) begin
         rsp_mask_ff <= active32;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_mask_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // a deleted slot keeps its bit until the rebuild walk reaches it
   `ASSERT_IMPL(a_inactive_empty, clock, reset, (state_ff == til_pkg::ST_IDLE), ((active_ff & ~valid_ff) == '0), "active bit on empty slot")
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, accept, !req_tready, "ready during command")
   `ASSERT_IMPL(a_time_on_set, clock, reset, (!$past(reset) && !$stable(last_time_ff)), ($past(cmd_ff) == til_pkg::CMD_SET && $past(load_rsp)), "time moved outside set")

endmodule

// ===== hdl/til_bound_mem.sv =====
// ----------------------------------------------------------------------------
// til_bound_mem
// Interval bound store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module til_bound_mem #(
   parameter int SLOTS = til_pkg::SLOTS_DEF
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   input  til_pkg::bound_type                       wr_data,
   input  logic                                     rd_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output til_pkg::bound_type                       rd_data
);

   til_pkg::bound_type mem_ff [SLOTS];
   til_pkg::bound_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/til_cross_unit.sv =====
// ----------------------------------------------------------------------------
// til_cross_unit
// Shared crossing unit: next active bit of one slot for a rebuild or a move.
// ----------------------------------------------------------------------------
module til_cross_unit (
   input  til_pkg::mode_type                  mode,
   input  til_pkg::bound_type                 bound,
   input  logic signed [til_pkg::TIME_W-1:0]  last_time,
   input  logic signed [til_pkg::TIME_W-1:0]  new_time,
   input  logic                               slot_valid,
   input  logic                               cur_bit,
   output logic                               next_bit
);

   logic s_le_last;
   logic e_le_last;
   logic s_le_new;
   logic e_le_new;
   logic set_bit;
   logic clr_bit;

   assign s_le_last = (bound.start_time <= last_time);
   assign e_le_last = (bound.end_time <= last_time);
   assign s_le_new  = (bound.start_time <= new_time);
   assign e_le_new  = (bound.end_time <= new_time);

   always_comb begin
      set_bit  = 1'b0;
      clr_bit  = 1'b0;
      next_bit = cur_bit;
      case (mode)
         til_pkg::MODE_REBUILD: begin
            next_bit = slot_valid & (s_le_last ^ e_le_last);
         end
         til_pkg::MODE_FWD: begin
            set_bit  = !s_le_last && s_le_new;
            clr_bit  = !e_le_last && e_le_new;
            next_bit = slot_valid ? ((cur_bit | set_bit) & !clr_bit) : cur_bit;
         end
         til_pkg::MODE_BACK: begin
            set_bit  = !e_le_new && e_le_last;
            clr_bit  = !s_le_new && s_le_last;
            next_bit = slot_valid ? ((cur_bit | set_bit) & !clr_bit) : cur_bit;
         end
         default: begin
            next_bit = cur_bit;
         end
      endcase
   end

endmodule
